// ===== rtl/core/mud_pkg.sv =====
`default_nettype none
package mud_pkg;

  localparam int MAX_UOPS = 64;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  typedef logic [5:0] uop_t;

  // addressing micro-ops
  localparam uop_t A_IMM      = 6'd0;
  localparam uop_t A_ABS      = 6'd1;
  localparam uop_t A_ABS_NR   = 6'd2;
  localparam uop_t A_ABS_X    = 6'd3;
  localparam uop_t A_ABS_X_NR = 6'd4;
  localparam uop_t A_ABS_Y    = 6'd5;
  localparam uop_t A_ABS_Y_NR = 6'd6;
  localparam uop_t A_ZP       = 6'd7;
  localparam uop_t A_ZP_NR    = 6'd8;
  localparam uop_t A_ZP_X     = 6'd9;
  localparam uop_t A_ZP_X_NR  = 6'd10;
  localparam uop_t A_ZP_Y     = 6'd11;
  localparam uop_t A_ZP_Y_NR  = 6'd12;
  localparam uop_t A_ZP_XI    = 6'd13;
  localparam uop_t A_ZP_XI_NR = 6'd14;
  localparam uop_t A_ZP_IY    = 6'd15;
  localparam uop_t A_ZP_IY_NR = 6'd16;

  // body micro-ops
  localparam uop_t U_P_UNSET  = 6'd17;
  localparam uop_t U_P_SET    = 6'd18;
  localparam uop_t U_MOV      = 6'd19;
  localparam uop_t U_MOV_NF   = 6'd20;
  localparam uop_t U_LOAD     = 6'd21;
  localparam uop_t U_STORE    = 6'd22;
  localparam uop_t U_CMP      = 6'd23;
  localparam uop_t U_ADD_MEM  = 6'd24;
  localparam uop_t U_ADD_REG  = 6'd25;
  localparam uop_t U_BR_UNSET = 6'd26;
  localparam uop_t U_BR_SET   = 6'd27;
  localparam uop_t U_JMP      = 6'd28;
  localparam uop_t U_JMP_IND  = 6'd29;
  localparam uop_t U_JSR      = 6'd30;
  localparam uop_t U_RTS      = 6'd31;
  localparam uop_t U_ORA      = 6'd32;
  localparam uop_t U_AND      = 6'd33;
  localparam uop_t U_EOR      = 6'd34;
  localparam uop_t U_ADC      = 6'd35;
  localparam uop_t U_ASL      = 6'd36;
  localparam uop_t U_ASL_REG  = 6'd37;
  localparam uop_t U_ROL      = 6'd38;
  localparam uop_t U_ROL_REG  = 6'd39;
  localparam uop_t U_LSR      = 6'd40;
  localparam uop_t U_LSR_REG  = 6'd41;
  localparam uop_t U_ROR      = 6'd42;
  localparam uop_t U_ROR_REG  = 6'd43;

  localparam logic [7:0] F_C = 8'h01;
  localparam logic [7:0] F_Z = 8'h02;
  localparam logic [7:0] F_I = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_V = 8'h40;
  localparam logic [7:0] F_N = 8'h80;

  localparam logic [1:0] R_A = 2'd0;
  localparam logic [1:0] R_X = 2'd1;
  localparam logic [1:0] R_Y = 2'd2;
  localparam logic [1:0] R_S = 2'd3;

  localparam logic [7:0] INC_ONE = 8'h01;
  localparam logic [7:0] DEC_ONE = 8'hff;

  typedef struct packed {
    logic       vld;
    uop_t       code;
    logic [1:0] alen;
  } addr_t;

  typedef struct packed {
    logic        vld;
    uop_t        code;
    logic [1:0]  len;
    logic [15:0] pl;
  } body_t;

  // one decoded instruction, front to back
  typedef struct packed {
    logic        a_vld;
    uop_t        a_code;
    logic        b_vld;
    uop_t        b_code;
    logic [1:0]  b_len;
    logic [15:0] b_pl;
    logic [15:0] opnd;
    logic        done;
  } rec_t;

  typedef struct packed {
    uop_t        code;
    logic [1:0]  len;
    logic [15:0] pl;
    logic        nu;
    logic        last;
    logic        done;
  } res_t;

  function automatic addr_t addr_kind(input logic [7:0] op);
    addr_t r;
    r = '0;
    r.vld = 1'b1;
    r.alen = 2'd2;
    unique case (op)
      8'h09, 8'h29, 8'h49, 8'h69, 8'h89, 8'ha9, 8'hc9, 8'he9,
      8'h0b, 8'h2b, 8'h4b, 8'h6b, 8'h8b, 8'hab, 8'hcb, 8'heb,
      8'h80, 8'ha0, 8'hc0, 8'he0, 8'h82, 8'ha2, 8'hc2, 8'he2: begin
        r.code = A_IMM; r.alen = 2'd1;
      end
      8'h0d, 8'h2d, 8'h4d, 8'h6d, 8'had, 8'hcd, 8'hed,
      8'h0e, 8'h2e, 8'h4e, 8'h6e, 8'hae, 8'hce, 8'hee,
      8'h0f, 8'h2f, 8'h4f, 8'h6f, 8'haf, 8'hcf, 8'hef,
      8'h0c, 8'h2c, 8'hac, 8'hcc, 8'hec: r.code = A_ABS;
      8'h8c, 8'h8d, 8'h8e, 8'h8f: r.code = A_ABS_NR;
      8'h1c, 8'h3c, 8'h5c, 8'h7c, 8'h9c, 8'hbc, 8'hdc, 8'hfc,
      8'h1d, 8'h3d, 8'h5d, 8'h7d, 8'hbd, 8'hdd, 8'hfd,
      8'h1e, 8'h3e, 8'h5e, 8'h7e, 8'hde, 8'hfe,
      8'h1f, 8'h3f, 8'h5f, 8'h7f, 8'hdf, 8'hff: r.code = A_ABS_X;
      8'h9d: r.code = A_ABS_X_NR;
      8'h19, 8'h39, 8'h59, 8'h79, 8'hb9, 8'hd9, 8'hf9,
      8'h1b, 8'h3b, 8'h5b, 8'h7b, 8'h9b, 8'hbb, 8'hdb, 8'hfb,
      8'h9e, 8'hbe, 8'h9f, 8'hbf: r.code = A_ABS_Y;
      8'h99: r.code = A_ABS_Y_NR;
      8'h04, 8'h24, 8'h44, 8'h64, 8'ha4, 8'hc4, 8'he4,
      8'h05, 8'h25, 8'h45, 8'h65, 8'ha5, 8'hc5, 8'he5,
      8'h06, 8'h26, 8'h46, 8'h66, 8'ha6, 8'hc6, 8'he6,
      8'h07, 8'h27, 8'h47, 8'h67, 8'ha7, 8'hc7, 8'he7: begin
        r.code = A_ZP; r.alen = 2'd1;
      end
      8'h84, 8'h85, 8'h86, 8'h87: begin
        r.code = A_ZP_NR; r.alen = 2'd1;
      end
      8'h14, 8'h34, 8'h54, 8'h74, 8'hb4, 8'hd4, 8'hf4,
      8'h15, 8'h35, 8'h55, 8'h75, 8'hb5, 8'hd5, 8'hf5,
      8'h16, 8'h36, 8'h56, 8'h76, 8'hd6, 8'hf6,
      8'h17, 8'h37, 8'h57, 8'h77, 8'hd7, 8'hf7: begin
        r.code = A_ZP_X; r.alen = 2'd1;
      end
      8'h94, 8'h95: begin
        r.code = A_ZP_X_NR; r.alen = 2'd1;
      end
      8'hb6, 8'hb7: begin
        r.code = A_ZP_Y; r.alen = 2'd1;
      end
      8'h96, 8'h97: begin
        r.code = A_ZP_Y_NR; r.alen = 2'd1;
      end
      8'h01, 8'h21, 8'h41, 8'h61, 8'ha1, 8'hc1, 8'he1,
      8'h03, 8'h23, 8'h43, 8'h63, 8'ha3, 8'hc3, 8'he3: begin
        r.code = A_ZP_XI; r.alen = 2'd1;
      end
      8'h81, 8'h83: begin
        r.code = A_ZP_XI_NR; r.alen = 2'd1;
      end
      8'h11, 8'h31, 8'h51, 8'h71, 8'hb1, 8'hd1, 8'hf1,
      8'h13, 8'h33, 8'h53, 8'h73, 8'hb3, 8'hd3, 8'hf3: begin
        r.code = A_ZP_IY; r.alen = 2'd1;
      end
      8'h91, 8'h93: begin
        r.code = A_ZP_IY_NR; r.alen = 2'd1;
      end
      default: begin
        r.vld = 1'b0; r.alen = 2'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] needed_operands(input logic [7:0] op);
    addr_t a;
    logic [1:0] n;
    a = addr_kind(op);
    unique case (op)
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0, 8'hf0: n = 2'd1;
      8'h4c, 8'h6c, 8'h20: n = 2'd2;
      default: n = 2'd0;
    endcase
    return a.vld ? a.alen : n;
  endfunction

  // m is the byte length of a memory op
  function automatic body_t body_kind(input logic [7:0] op, input logic [1:0] m,
                                      input logic [15:0] opnd);
    body_t r;
    r = '0;
    r.vld = 1'b1;
    r.len = m;
    unique case (op)
      8'h18: begin r.code = U_P_UNSET; r.len = 2'd1; r.pl = {8'h0, F_C}; end
      8'h58: begin r.code = U_P_UNSET; r.len = 2'd1; r.pl = {8'h0, F_I}; end
      8'hb8: begin r.code = U_P_UNSET; r.len = 2'd1; r.pl = {8'h0, F_V}; end
      8'hd8: begin r.code = U_P_UNSET; r.len = 2'd1; r.pl = {8'h0, F_D}; end
      8'h38: begin r.code = U_P_SET;   r.len = 2'd1; r.pl = {8'h0, F_C}; end
      8'h78: begin r.code = U_P_SET;   r.len = 2'd1; r.pl = {8'h0, F_I}; end
      8'hf8: begin r.code = U_P_SET;   r.len = 2'd1; r.pl = {8'h0, F_D}; end
      8'haa: begin r.code = U_MOV;    r.len = 2'd1; r.pl = {12'h0, R_X, R_A}; end
      8'ha8: begin r.code = U_MOV;    r.len = 2'd1; r.pl = {12'h0, R_Y, R_A}; end
      8'hba: begin r.code = U_MOV_NF; r.len = 2'd1; r.pl = {12'h0, R_X, R_S}; end
      8'h8a: begin r.code = U_MOV;    r.len = 2'd1; r.pl = {12'h0, R_A, R_X}; end
      8'h9a: begin r.code = U_MOV;    r.len = 2'd1; r.pl = {12'h0, R_S, R_X}; end
      8'h98: begin r.code = U_MOV;    r.len = 2'd1; r.pl = {12'h0, R_A, R_Y}; end
      8'he8: begin r.code = U_ADD_REG; r.len = 2'd1; r.pl = {6'h0, R_X, INC_ONE}; end
      8'hc8: begin r.code = U_ADD_REG; r.len = 2'd1; r.pl = {6'h0, R_Y, INC_ONE}; end
      8'hca: begin r.code = U_ADD_REG; r.len = 2'd1; r.pl = {6'h0, R_X, DEC_ONE}; end
      8'h88: begin r.code = U_ADD_REG; r.len = 2'd1; r.pl = {6'h0, R_Y, DEC_ONE}; end
      8'h0a: begin r.code = U_ASL_REG; r.len = 2'd1; end
      8'h2a: begin r.code = U_ROL_REG; r.len = 2'd1; end
      8'h4a: begin r.code = U_LSR_REG; r.len = 2'd1; end
      8'h6a: begin r.code = U_ROR_REG; r.len = 2'd1; end
      8'h60: begin r.code = U_RTS;     r.len = 2'd1; end
      8'h10: begin r.code = U_BR_UNSET; r.len = 2'd2; r.pl = {opnd[7:0], F_N}; end
      8'h50: begin r.code = U_BR_UNSET; r.len = 2'd2; r.pl = {opnd[7:0], F_V}; end
      8'h90: begin r.code = U_BR_UNSET; r.len = 2'd2; r.pl = {opnd[7:0], F_C}; end
      8'hd0: begin r.code = U_BR_UNSET; r.len = 2'd2; r.pl = {opnd[7:0], F_Z}; end
      8'h30: begin r.code = U_BR_SET;   r.len = 2'd2; r.pl = {opnd[7:0], F_N}; end
      8'h70: begin r.code = U_BR_SET;   r.len = 2'd2; r.pl = {opnd[7:0], F_V}; end
      8'hb0: begin r.code = U_BR_SET;   r.len = 2'd2; r.pl = {opnd[7:0], F_C}; end
      8'hf0: begin r.code = U_BR_SET;   r.len = 2'd2; r.pl = {opnd[7:0], F_Z}; end
      8'h4c: begin r.code = U_JMP;     r.len = 2'd3; r.pl = opnd; end
      8'h6c: begin r.code = U_JMP_IND; r.len = 2'd3; r.pl = opnd; end
      8'h20: begin r.code = U_JSR;     r.len = 2'd3; r.pl = opnd; end
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: begin
        r.code = U_LOAD; r.pl = {14'h0, R_A};
      end
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe: begin r.code = U_LOAD; r.pl = {14'h0, R_X}; end
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc: begin r.code = U_LOAD; r.pl = {14'h0, R_Y}; end
      8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d: begin
        r.code = U_STORE; r.pl = {14'h0, R_A};
      end
      8'h86, 8'h8e, 8'h96: begin r.code = U_STORE; r.pl = {14'h0, R_X}; end
      8'h84, 8'h8c, 8'h94: begin r.code = U_STORE; r.pl = {14'h0, R_Y}; end
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: begin
        r.code = U_CMP; r.pl = {14'h0, R_A};
      end
      8'he0, 8'he4, 8'hec: begin r.code = U_CMP; r.pl = {14'h0, R_X}; end
      8'hc0, 8'hc4, 8'hcc: begin r.code = U_CMP; r.pl = {14'h0, R_Y}; end
      8'he6, 8'hee, 8'hf6, 8'hfe: begin r.code = U_ADD_MEM; r.pl = {8'h0, INC_ONE}; end
      8'hc6, 8'hce, 8'hd6, 8'hde: begin r.code = U_ADD_MEM; r.pl = {8'h0, DEC_ONE}; end
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: r.code = U_ORA;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: r.code = U_AND;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: r.code = U_EOR;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: r.code = U_ADC;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: begin
        r.code = U_ADC; r.pl = {8'h0, DEC_ONE};
      end
      8'h06, 8'h0e, 8'h16, 8'h1e: r.code = U_ASL;
      8'h26, 8'h2e, 8'h36, 8'h3e: r.code = U_ROL;
      8'h46, 8'h4e, 8'h56, 8'h5e: r.code = U_LSR;
      8'h66, 8'h6e, 8'h76, 8'h7e: r.code = U_ROR;
      default: begin
        r.vld = 1'b0; r.len = 2'd0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mud_front.sv =====
`default_nettype none
module mud_front import mud_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] code_byte,
  input  wire logic       trace_start,
  input  wire logic       q_full,
  output logic            push,
  output rec_t            rec
);

  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_LOW    = 2'd1;
  localparam logic [1:0] PH_HIGH   = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [7:0]  opcode_latch, opcode_latch_next;
  logic [7:0]  operand_low, operand_low_next;
  logic [6:0]  uop_count, uop_count_next;
  logic        trace_closed, trace_closed_next;

  logic        acc;
  logic [1:0]  eph;
  logic [6:0]  cnt_e;
  logic [6:0]  cnt_sum;
  logic        complete;
  logic        ends;
  logic [7:0]  op_c;
  logic [15:0] opnd;
  addr_t       ak;
  body_t       bk;

  always_comb begin
    in_ready = !q_full;
    acc = in_valid && in_ready;
    eph = trace_start ? PH_OPCODE : phase;
    cnt_e = trace_start ? 7'd0 : uop_count;

    phase_next = phase;
    opcode_latch_next = opcode_latch;
    operand_low_next = operand_low;
    uop_count_next = uop_count;
    trace_closed_next = trace_closed;
    complete = 1'b0;
    op_c = opcode_latch;
    opnd = '0;

    if (acc && (trace_start || !trace_closed)) begin
      phase_next = eph;
      uop_count_next = cnt_e;
      trace_closed_next = 1'b0;
      unique case (eph)
        PH_LOW: begin
          if (needed_operands(opcode_latch) == 2'd1) begin
            complete = 1'b1;
            opnd = {8'h0, code_byte};
          end else begin
            operand_low_next = code_byte;
            phase_next = PH_HIGH;
          end
        end
        PH_HIGH: begin
          complete = 1'b1;
          opnd = {code_byte, operand_low};
        end
        default: begin
          op_c = code_byte;
          opcode_latch_next = code_byte;
          if (needed_operands(code_byte) == 2'd0) begin
            complete = 1'b1;
          end else begin
            phase_next = PH_LOW;
          end
        end
      endcase
    end

    ak = addr_kind(op_c);
    bk = body_kind(op_c, 2'(ak.alen + 2'd1), opnd);
    cnt_sum = 7'(cnt_e + {6'd0, ak.vld} + {6'd0, bk.vld});
    ends = (bk.vld && bk.code >= U_BR_UNSET && bk.code <= U_RTS)
        || (cnt_sum >= 7'(MAX_UOPS - 4));

    if (complete) begin
      phase_next = PH_OPCODE;
      uop_count_next = cnt_sum;
      trace_closed_next = ends;
    end

    push = complete;
    rec.a_vld = ak.vld;
    rec.a_code = ak.code;
    rec.b_vld = bk.vld;
    rec.b_code = bk.code;
    rec.b_len = bk.len;
    rec.b_pl = bk.pl;
    rec.opnd = opnd;
    rec.done = ends;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPCODE;
      opcode_latch <= '0;
      operand_low <= '0;
      uop_count <= '0;
      trace_closed <= 1'b1;
    end else begin
      phase <= phase_next;
      opcode_latch <= opcode_latch_next;
      operand_low <= operand_low_next;
      uop_count <= uop_count_next;
      trace_closed <= trace_closed_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mud_queue.sv =====
`default_nettype none
module mud_queue import mud_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  rec_t      wr_rec,
  output logic      full,
  output logic      head_vld,
  output rec_t      head,
  input  wire logic pop
);

  rec_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  always_comb begin
    full = (count == (QAW+1)'(QDEPTH));
    head_vld = (count != '0);
    head = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mud_back.sv =====
`default_nettype none
module mud_back import mud_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_vld,
  input  rec_t      head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res
);

  logic sub_sent, sub_sent_next;
  logic load;
  logic take;
  res_t cand;

  always_comb begin
    load = !out_valid || out_ready;
    take = head_vld && load;
    cand = '0;
    pop = 1'b0;
    sub_sent_next = sub_sent;
    priority if (!sub_sent && head.a_vld) begin
      // addressing micro-op first
      cand.code = head.a_code;
      cand.pl = head.opnd;
      cand.last = !head.b_vld;
      cand.done = !head.b_vld && head.done;
      if (take) begin
        if (head.b_vld) begin
          sub_sent_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end
    end else if (head.b_vld) begin
      cand.code = head.b_code;
      cand.len = head.b_len;
      cand.pl = head.b_pl;
      cand.last = 1'b1;
      cand.done = head.done;
      if (take) begin
        pop = 1'b1;
        sub_sent_next = 1'b0;
      end
    end else begin
      // opcode with no micro-op
      cand.nu = 1'b1;
      cand.last = 1'b1;
      cand.done = head.done;
      if (take) begin
        pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub_sent <= 1'b0;
    end else begin
      sub_sent <= sub_sent_next;
      if (load) begin
        out_valid <= head_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= cand;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mos6502_uop_decoder_top.sv =====
`default_nettype none
// channel   dir  signals                                   per item
// s_axis    in   tdata[7:0] code_byte, tuser trace_start   one code byte
// m_axis    out  tdata uop_code/length/payload, tlast,     one micro-op result
//                tuser no_uop/trace_done
//
// one code byte accepted per cycle while the decode queue is not full; a finished
// instruction passes through a four-entry decode queue into the output register,
// and a two-micro-op instruction leaves as two results, addressing micro-op first
// rst clears phase, micro-op count and queue; the trace starts closed
// s_axis_tready drops only while the decode queue is full
module mos6502_uop_decoder_top import mud_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // code_byte
  input  wire logic        s_axis_tuser,  // trace_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // uop_code[5:0], uop_length[7:6], uop_payload[23:8]
  output logic             m_axis_tlast,  // instr_last
  output logic [1:0]       m_axis_tuser   // no_uop[0], trace_done[1]
);

  logic q_full;
  logic push;
  rec_t wr_rec;
  logic head_vld;
  rec_t head;
  logic pop;
  res_t res;

  mud_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .code_byte   (s_axis_tdata),
    .trace_start (s_axis_tuser),
    .q_full      (q_full),
    .push        (push),
    .rec         (wr_rec)
  );

  mud_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (wr_rec),
    .full     (q_full),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop)
  );

  mud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.pl, res.len, res.code};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.done, res.nu};

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("decode queue overflow");

  a_no_uop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && m_axis_tlast))
    else $error("no_uop result with nonzero fields");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("trace_done before last result");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:0] <= U_ROR_REG))
    else $error("micro-op code out of range");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
  import mud_pkg::*;

  typedef struct packed {
    uop_t        code;
    logic [1:0]  len;
    logic [15:0] pl;
    logic        nu;
    logic        last;
    logic        done;
  } uop_rec_t;

  typedef struct packed {
    logic       has;
    uop_t       code;
    logic [1:0] nb;
  } amode_t;

  typedef struct packed {
    logic        has;
    uop_t        code;
    logic [1:0]  len;
    logic [15:0] pl;
  } body_op_t;

  typedef struct packed {
    logic [7:0] cb;
    logic       st;
    logic       typed;
    logic [1:0] tn;
    uop_rec_t   res;
  } dir_row_t;

  localparam uop_rec_t RES_NONE = '0;
  localparam uop_rec_t RES_UNKNOWN = '{code: A_IMM, len: 2'd0, pl: 16'h0,
                                       nu: 1'b1, last: 1'b1, done: 1'b0};
  localparam uop_rec_t RES_RTS = '{code: U_RTS, len: 2'd1, pl: 16'h0,
                                   nu: 1'b0, last: 1'b1, done: 1'b1};

  // code byte, trace start, typed expectation, typed count, typed result
  localparam dir_row_t DIRECTED [24] = '{
    '{8'h18, 1'b0, 1'b1, 2'd0, RES_NONE},     // closed after reset
    '{8'h02, 1'b1, 1'b1, 2'd1, RES_UNKNOWN},  // unknown opcode
    '{8'ha9, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'had, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h0a, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, 2'd0, RES_NONE},     // addressing only
    '{8'h34, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h12, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h8d, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h10, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'he8, 1'b1, 1'b0, 2'd0, RES_NONE},     // restart mid-instruction
    '{8'h60, 1'b0, 1'b1, 2'd1, RES_RTS},
    '{8'h60, 1'b0, 1'b1, 2'd0, RES_NONE},     // closed after rts
    '{8'hf0, 1'b1, 1'b0, 2'd0, RES_NONE},
    '{8'h80, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h4c, 1'b1, 1'b0, 2'd0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h20, 1'b1, 1'b0, 2'd0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, RES_NONE}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // code_byte
  logic        s_axis_tuser;   // trace_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // uop_code[5:0], uop_length[7:6], uop_payload[23:8]
  logic        m_axis_tlast;   // instr_last
  logic [1:0]  m_axis_tuser;   // no_uop[0], trace_done[1]

  mos6502_uop_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // decoder state as the predictor sees it
  logic [1:0] ph;
  logic [7:0] opc;
  logic [7:0] lo;
  logic [6:0] cnt;
  logic       closed;

  uop_rec_t pending_uops[$];
  uop_rec_t fresh[$];
  int       mismatches = 0;
  int       tx_idle = 0;
  int       rx_idle = 0;
  bit       hold_go = 0;
  uop_rec_t got_uop;
  uop_rec_t want_uop;

  function automatic amode_t addr_mode(input logic [7:0] op);
    amode_t m;
    m = '{has: 1'b1, code: A_IMM, nb: 2'd1};
    case (op)
      8'h09, 8'h29, 8'h49, 8'h69, 8'h89, 8'ha9, 8'hc9, 8'he9,
      8'h0b, 8'h2b, 8'h4b, 8'h6b, 8'h8b, 8'hab, 8'hcb, 8'heb,
      8'h80, 8'ha0, 8'hc0, 8'he0, 8'h82, 8'ha2, 8'hc2, 8'he2: m.code = A_IMM;
      8'h0d, 8'h2d, 8'h4d, 8'h6d, 8'had, 8'hcd, 8'hed,
      8'h0e, 8'h2e, 8'h4e, 8'h6e, 8'hae, 8'hce, 8'hee,
      8'h0f, 8'h2f, 8'h4f, 8'h6f, 8'haf, 8'hcf, 8'hef,
      8'h0c, 8'h2c, 8'hac, 8'hcc, 8'hec: begin
        m.code = A_ABS; m.nb = 2'd2;
      end
      8'h8c, 8'h8d, 8'h8e, 8'h8f: begin
        m.code = A_ABS_NR; m.nb = 2'd2;
      end
      8'h1c, 8'h3c, 8'h5c, 8'h7c, 8'h9c, 8'hbc, 8'hdc, 8'hfc,
      8'h1d, 8'h3d, 8'h5d, 8'h7d, 8'hbd, 8'hdd, 8'hfd,
      8'h1e, 8'h3e, 8'h5e, 8'h7e, 8'hde, 8'hfe,
      8'h1f, 8'h3f, 8'h5f, 8'h7f, 8'hdf, 8'hff: begin
        m.code = A_ABS_X; m.nb = 2'd2;
      end
      8'h9d: begin
        m.code = A_ABS_X_NR; m.nb = 2'd2;
      end
      8'h19, 8'h39, 8'h59, 8'h79, 8'hb9, 8'hd9, 8'hf9,
      8'h1b, 8'h3b, 8'h5b, 8'h7b, 8'h9b, 8'hbb, 8'hdb, 8'hfb,
      8'h9e, 8'hbe, 8'h9f, 8'hbf: begin
        m.code = A_ABS_Y; m.nb = 2'd2;
      end
      8'h99: begin
        m.code = A_ABS_Y_NR; m.nb = 2'd2;
      end
      8'h04, 8'h24, 8'h44, 8'h64, 8'ha4, 8'hc4, 8'he4,
      8'h05, 8'h25, 8'h45, 8'h65, 8'ha5, 8'hc5, 8'he5,
      8'h06, 8'h26, 8'h46, 8'h66, 8'ha6, 8'hc6, 8'he6,
      8'h07, 8'h27, 8'h47, 8'h67, 8'ha7, 8'hc7, 8'he7: m.code = A_ZP;
      8'h84, 8'h85, 8'h86, 8'h87: m.code = A_ZP_NR;
      8'h14, 8'h34, 8'h54, 8'h74, 8'hb4, 8'hd4, 8'hf4,
      8'h15, 8'h35, 8'h55, 8'h75, 8'hb5, 8'hd5, 8'hf5,
      8'h16, 8'h36, 8'h56, 8'h76, 8'hd6, 8'hf6,
      8'h17, 8'h37, 8'h57, 8'h77, 8'hd7, 8'hf7: m.code = A_ZP_X;
      8'h94, 8'h95: m.code = A_ZP_X_NR;
      8'hb6, 8'hb7: m.code = A_ZP_Y;
      8'h96, 8'h97: m.code = A_ZP_Y_NR;
      8'h01, 8'h21, 8'h41, 8'h61, 8'ha1, 8'hc1, 8'he1,
      8'h03, 8'h23, 8'h43, 8'h63, 8'ha3, 8'hc3, 8'he3: m.code = A_ZP_XI;
      8'h81, 8'h83: m.code = A_ZP_XI_NR;
      8'h11, 8'h31, 8'h51, 8'h71, 8'hb1, 8'hd1, 8'hf1,
      8'h13, 8'h33, 8'h53, 8'h73, 8'hb3, 8'hd3, 8'hf3: m.code = A_ZP_IY;
      8'h91, 8'h93: m.code = A_ZP_IY_NR;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] operand_bytes(input logic [7:0] op);
    amode_t m;
    m = addr_mode(op);
    if (m.has) return m.nb;
    case (op)
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0, 8'hf0: return 2'd1;
      8'h4c, 8'h6c, 8'h20: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic bit ends_trace(input logic [7:0] op);
    case (op)
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0, 8'hf0,
      8'h4c, 8'h6c, 8'h20, 8'h60: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // mlen is the byte length of a memory instruction
  function automatic body_op_t body_op(input logic [7:0] op, input logic [1:0] mlen,
                                       input logic [15:0] opnd);
    body_op_t b;
    b = '{has: 1'b1, code: U_P_UNSET, len: mlen, pl: 16'h0};
    case (op)
      8'h18: b.pl = {8'h0, F_C};
      8'h58: b.pl = {8'h0, F_I};
      8'hb8: b.pl = {8'h0, F_V};
      8'hd8: b.pl = {8'h0, F_D};
      8'h38: begin b.code = U_P_SET; b.pl = {8'h0, F_C}; end
      8'h78: begin b.code = U_P_SET; b.pl = {8'h0, F_I}; end
      8'hf8: begin b.code = U_P_SET; b.pl = {8'h0, F_D}; end
      8'haa: begin b.code = U_MOV; b.pl = {12'h0, R_X, R_A}; end
      8'ha8: begin b.code = U_MOV; b.pl = {12'h0, R_Y, R_A}; end
      8'hba: begin b.code = U_MOV_NF; b.pl = {12'h0, R_X, R_S}; end
      8'h8a: begin b.code = U_MOV; b.pl = {12'h0, R_A, R_X}; end
      8'h9a: begin b.code = U_MOV; b.pl = {12'h0, R_S, R_X}; end
      8'h98: begin b.code = U_MOV; b.pl = {12'h0, R_A, R_Y}; end
      8'he8: begin b.code = U_ADD_REG; b.pl = {6'h0, R_X, INC_ONE}; end
      8'hc8: begin b.code = U_ADD_REG; b.pl = {6'h0, R_Y, INC_ONE}; end
      8'hca: begin b.code = U_ADD_REG; b.pl = {6'h0, R_X, DEC_ONE}; end
      8'h88: begin b.code = U_ADD_REG; b.pl = {6'h0, R_Y, DEC_ONE}; end
      8'h0a: b.code = U_ASL_REG;
      8'h2a: b.code = U_ROL_REG;
      8'h4a: b.code = U_LSR_REG;
      8'h6a: b.code = U_ROR_REG;
      8'h60: b.code = U_RTS;
      8'h10: begin b.code = U_BR_UNSET; b.len = 2'd2; b.pl = {opnd[7:0], F_N}; end
      8'h50: begin b.code = U_BR_UNSET; b.len = 2'd2; b.pl = {opnd[7:0], F_V}; end
      8'h90: begin b.code = U_BR_UNSET; b.len = 2'd2; b.pl = {opnd[7:0], F_C}; end
      8'hd0: begin b.code = U_BR_UNSET; b.len = 2'd2; b.pl = {opnd[7:0], F_Z}; end
      8'h30: begin b.code = U_BR_SET; b.len = 2'd2; b.pl = {opnd[7:0], F_N}; end
      8'h70: begin b.code = U_BR_SET; b.len = 2'd2; b.pl = {opnd[7:0], F_V}; end
      8'hb0: begin b.code = U_BR_SET; b.len = 2'd2; b.pl = {opnd[7:0], F_C}; end
      8'hf0: begin b.code = U_BR_SET; b.len = 2'd2; b.pl = {opnd[7:0], F_Z}; end
      8'h4c: begin b.code = U_JMP; b.len = 2'd3; b.pl = opnd; end
      8'h6c: begin b.code = U_JMP_IND; b.len = 2'd3; b.pl = opnd; end
      8'h20: begin b.code = U_JSR; b.len = 2'd3; b.pl = opnd; end
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: begin
        b.code = U_LOAD; b.pl = {14'h0, R_A};
      end
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe: begin b.code = U_LOAD; b.pl = {14'h0, R_X}; end
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc: begin b.code = U_LOAD; b.pl = {14'h0, R_Y}; end
      8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d: begin
        b.code = U_STORE; b.pl = {14'h0, R_A};
      end
      8'h86, 8'h8e, 8'h96: begin b.code = U_STORE; b.pl = {14'h0, R_X}; end
      8'h84, 8'h8c, 8'h94: begin b.code = U_STORE; b.pl = {14'h0, R_Y}; end
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: begin
        b.code = U_CMP; b.pl = {14'h0, R_A};
      end
      8'he0, 8'he4, 8'hec: begin b.code = U_CMP; b.pl = {14'h0, R_X}; end
      8'hc0, 8'hc4, 8'hcc: begin b.code = U_CMP; b.pl = {14'h0, R_Y}; end
      8'he6, 8'hee, 8'hf6, 8'hfe: begin b.code = U_ADD_MEM; b.pl = {8'h0, INC_ONE}; end
      8'hc6, 8'hce, 8'hd6, 8'hde: begin b.code = U_ADD_MEM; b.pl = {8'h0, DEC_ONE}; end
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: b.code = U_ORA;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: b.code = U_AND;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: b.code = U_EOR;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: b.code = U_ADC;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: begin
        b.code = U_ADC; b.pl = {8'h0, DEC_ONE};
      end
      8'h06, 8'h0e, 8'h16, 8'h1e: b.code = U_ASL;
      8'h26, 8'h2e, 8'h36, 8'h3e: b.code = U_ROL;
      8'h46, 8'h4e, 8'h56, 8'h5e: b.code = U_LSR;
      8'h66, 8'h6e, 8'h76, 8'h7e: b.code = U_ROR;
      default: b = '0;
    endcase
    return b;
  endfunction

  task automatic finish_instr(input logic [7:0] op, input logic [15:0] opnd);
    amode_t   a;
    body_op_t b;
    bit       ends;
    uop_rec_t r;
    a = addr_mode(op);
    b = body_op(op, a.nb + 2'd1, opnd);
    ends = b.has && b.code >= U_BR_UNSET && b.code <= U_RTS;
    cnt = cnt + 7'(a.has) + 7'(b.has);
    if (cnt >= 7'(MAX_UOPS - 4)) ends = 1'b1;
    fresh.delete();
    if (!a.has && !b.has) begin
      r = '0;
      r.nu = 1'b1;
      r.last = 1'b1;
      r.done = ends;
      fresh.push_back(r);
    end else begin
      if (a.has) begin
        r = '0;
        r.code = a.code;
        r.pl = opnd;
        r.last = !b.has;
        r.done = !b.has && ends;
        fresh.push_back(r);
      end
      if (b.has) begin
        r = '0;
        r.code = b.code;
        r.len = b.len;
        r.pl = b.pl;
        r.last = 1'b1;
        r.done = ends;
        fresh.push_back(r);
      end
    end
    if (ends) closed = 1'b1;
    ph = 2'd0;
  endtask

  task automatic decode_code_byte(input logic [7:0] cb, input logic st, output bit taken);
    fresh.delete();
    taken = 1'b1;
    if (st) begin
      ph = 2'd0;
      cnt = '0;
      closed = 1'b0;
    end else if (closed) begin
      taken = 1'b0;
      return;
    end
    case (ph)
      2'd1: begin
        if (operand_bytes(opc) == 2'd1) begin
          finish_instr(opc, {8'h0, cb});
        end else begin
          lo = cb;
          ph = 2'd2;
        end
      end
      2'd2: finish_instr(opc, {cb, lo});
      default: begin
        opc = cb;
        if (operand_bytes(cb) == 2'd0) begin
          finish_instr(cb, 16'h0);
        end else begin
          ph = 2'd1;
        end
      end
    endcase
  endtask

  task automatic put_byte(input logic [7:0] cb, input logic st, input logic typed,
                          input logic [1:0] tn, input uop_rec_t tres, output bit taken);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cb;
    s_axis_tuser <= st;
    do @(posedge clk); while (!s_axis_tready);
    decode_code_byte(cb, st, taken);
    if (typed) begin
      for (int i = 0; i < tn; i++) pending_uops.push_back(tres);
    end else begin
      foreach (fresh[i]) pending_uops.push_back(fresh[i]);
    end
  endtask

  task automatic put(input logic [7:0] cb, input logic st, output bit taken);
    put_byte(cb, st, 1'b0, 2'd0, RES_NONE, taken);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

  // receiver, with one long hold-off in the last phase
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_uop.code = m_axis_tdata[5:0];
      got_uop.len = m_axis_tdata[7:6];
      got_uop.pl = m_axis_tdata[23:8];
      got_uop.nu = m_axis_tuser[0];
      got_uop.last = m_axis_tlast;
      got_uop.done = m_axis_tuser[1];
      if (pending_uops.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual %0d %0d %h %b %b %b",
                 $time, got_uop.code, got_uop.len, got_uop.pl, got_uop.nu, got_uop.last,
                 got_uop.done);
      end else begin
        want_uop = pending_uops.pop_front();
        if (got_uop !== want_uop) begin
          mismatches++;
          $display("%0t: expected %0d %0d %h %b %b %b, actual %0d %0d %h %b %b %b",
                   $time, want_uop.code, want_uop.len, want_uop.pl, want_uop.nu,
                   want_uop.last, want_uop.done, got_uop.code, got_uop.len, got_uop.pl,
                   got_uop.nu, got_uop.last, got_uop.done);
        end
      end
    end
  end

  initial begin
    bit         taken;
    bit         force_st;
    bit         long_run;
    logic       st;
    logic [7:0] op;
    int         nb;
    int         taken_items;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h0;
    s_axis_tuser <= 1'b0;
    ph = 2'd0;
    opc = 8'h0;
    lo = 8'h0;
    cnt = '0;
    closed = 1'b1;
    force_st = 1'b0;
    long_run = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      put_byte(DIRECTED[i].cb, DIRECTED[i].st, DIRECTED[i].typed, DIRECTED[i].tn,
               DIRECTED[i].res, taken);
    end

    // straight-line trace that runs into the micro-op limit
    put(INC_ONE == 8'h01 ? 8'he8 : 8'he8, 1'b1, taken);
    repeat (60) put(8'he8, 1'b0, taken);

    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      tx_idle = (phase_i == 0) ? 21 : (phase_i == 1) ? 66 : 0;
      rx_idle = (phase_i == 0) ? 66 : (phase_i == 1) ? 21 : 0;
      if (phase_i == 2) hold_go = 1'b1;
      taken_items = 0;
      while (taken_items < 120) begin
        // noise while the trace is closed
        if (closed && $urandom_range(9) == 0) put(8'($urandom_range(255)), 1'b0, taken);
        st = closed || force_st || ($urandom_range(long_run ? 199 : 24) == 0);
        if (st) long_run = ($urandom_range(3) == 0);
        force_st = 1'b0;
        op = 8'($urandom_range(255));
        if (long_run) begin
          while (ends_trace(op)) op = 8'($urandom_range(255));
        end
        put(op, st, taken);
        if (taken) taken_items++;
        nb = int'(operand_bytes(op));
        for (int k = 0; k < nb; k++) begin
          // broken instruction, next byte opens a new trace
          if ($urandom_range(39) == 0) begin
            force_st = 1'b1;
            break;
          end
          put(8'($urandom_range(255)), 1'b0, taken);
          if (taken) taken_items++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_uops.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
